>>> rtl/lrtm_pkg.sv
// Shared types and constants of the looping resampling track mixer.
`timescale 1ns / 1ps

package lrtm_pkg;

  localparam int CURSOR_W  = 32;
  localparam int FRAMES_W  = 17;
  localparam int LIMIT_W   = FRAMES_W + 16;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_MIX     = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN    = 2'd3;

  localparam logic [19:0] PHASE_STEP_RST = 20'd65536;
  localparam logic [17:0] MIX_GAIN_RST   = 18'd42598;

  typedef struct packed {
    logic accept;
    logic mod_start;
    logic mod_sel_next;
    logic red_from_mod;
    logic rd_sel_b;
    logic capture_wa;
    logic mul1;
    logic mul2;
    logic out_load;
    logic out_pass;
    logic cursor_from_next;
    logic cursor_from_mod;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_mix;
    logic bypass;
    logic cur_in_range;
    logic next_in_range;
    logic mod_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/lrtm_mod.sv
// Bit-serial restoring remainder unit used to wrap the playback cursor.
`timescale 1ns / 1ps

module lrtm_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lrtm_pkg::LIMIT_W-1:0] dividend,
  input  logic [lrtm_pkg::LIMIT_W-1:0] divisor,
  output logic                         done,
  output logic [lrtm_pkg::LIMIT_W-1:0] remainder
);
  import lrtm_pkg::*;

  localparam int CNT_W = $clog2(LIMIT_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] dvd_r, dvd_nxt;
  logic [LIMIT_W-1:0] div_r, div_nxt;
  logic [LIMIT_W-1:0] rem_r, rem_nxt;
  logic [LIMIT_W:0]   trial;

  // One dividend bit is brought down per cycle; the remainder stays below the divisor.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[LIMIT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(LIMIT_W);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[LIMIT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = LIMIT_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[LIMIT_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> rtl/lrtm_datapath.sv
// Datapath: configuration, track store, cursor, interpolation, gain and output register.
`timescale 1ns / 1ps

module lrtm_datapath #(
  parameter int FRAME_ADDR_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lrtm_pkg::ctrl_cmd_t                   cmd,
  output lrtm_pkg::dp_status_t                  status,
  input  logic [1:0]                            in_opcode,
  input  logic [15:0]                           in_frame_index,
  input  logic signed [lrtm_pkg::SAMPLE_W-1:0]  in_left_sample,
  input  logic signed [lrtm_pkg::SAMPLE_W-1:0]  in_right_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lrtm_pkg::SAMPLE_W-1:0]  out_mixed_left,
  output logic signed [lrtm_pkg::SAMPLE_W-1:0]  out_mixed_right,
  input  logic                                  cfg_wr_en,
  input  logic [lrtm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lrtm_pkg::CFG_W-1:0]            cfg_data
);
  import lrtm_pkg::*;

  localparam int          FAB   = FRAME_ADDR_BITS;
  localparam int unsigned DEPTH = 1 << FAB;

  // Configuration registers.
  logic                play_r;
  logic [FRAMES_W-1:0] count_r;
  logic [19:0]         step_r;
  logic [17:0]         gain_r;

  logic [CURSOR_W-1:0] cursor_r;
  logic [CURSOR_W-1:0] red_r;
  logic [LIMIT_W-1:0]  next_r;

  logic [31:0]         mem [DEPTH];
  logic [31:0]         rd_q_r;
  logic [31:0]         wa_r;

  logic signed [SAMPLE_W-1:0] smp_r [2];
  logic signed [33:0]         prod_r [2];
  logic signed [52:0]         track_r [2];

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r;

  logic [FRAMES_W-1:0] frames;
  logic [LIMIT_W-1:0]  limit;
  logic [LIMIT_W-1:0]  next_sum;
  logic [15:0]         idx_a;
  logic [FRAMES_W-1:0] idx_b1, idx_b;
  logic [FAB-1:0]      rd_addr;
  logic                mod_done;
  logic [LIMIT_W-1:0]  mod_rem;
  logic                out_free;
  logic signed [SAMPLE_W-1:0] mixed [2];

  always_comb begin
    if (32'(count_r) > DEPTH) begin
      frames = FRAMES_W'(DEPTH);
    end else begin
      frames = count_r;
    end
  end

  assign limit    = {frames, 16'b0};
  assign next_sum = LIMIT_W'(cursor_r) + LIMIT_W'(step_r);
  assign out_free = !out_valid_r || !out_stall;

  assign idx_a  = red_r[31:16];
  assign idx_b1 = FRAMES_W'(idx_a) + 1'b1;
  assign idx_b  = (idx_b1 >= frames) ? '0 : idx_b1;
  assign rd_addr = cmd.rd_sel_b ? FAB'(idx_b) : FAB'(idx_a);

  assign status.op_mix        = (in_opcode == OP_MIX);
  assign status.bypass        = !play_r || (frames == '0);
  assign status.cur_in_range  = LIMIT_W'(cursor_r) < limit;
  assign status.next_in_range = next_r < limit;
  assign status.mod_done      = mod_done;
  assign status.out_free      = out_free;

  lrtm_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (cmd.mod_sel_next ? next_r : LIMIT_W'(cursor_r)),
    .divisor   (limit),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r   <= 1'b0;
      count_r  <= '0;
      step_r   <= PHASE_STEP_RST;
      gain_r   <= MIX_GAIN_RST;
      cursor_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PLAY_ENABLE: play_r  <= cfg_data[0];
          CFG_FRAME_COUNT: count_r <= cfg_data[FRAMES_W-1:0];
          CFG_PHASE_STEP:  step_r  <= cfg_data[19:0];
          CFG_MIX_GAIN:    gain_r  <= cfg_data[17:0];
          default: ;
        endcase
      end
      if (cmd.accept && in_opcode == OP_RESTART) begin
        cursor_r <= '0;
      end else if (cmd.cursor_from_next) begin
        cursor_r <= next_r[CURSOR_W-1:0];
      end else if (cmd.cursor_from_mod) begin
        cursor_r <= mod_rem[CURSOR_W-1:0];
      end
    end
  end

  // Track store: one port, written by write items, read twice per mixed item.
  always_ff @(posedge clk) begin
    if (cmd.accept && in_opcode == OP_WRITE) begin
      mem[FAB'(in_frame_index)] <= {in_right_sample, in_left_sample};
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r[0] <= in_left_sample;
      smp_r[1] <= in_right_sample;
      red_r    <= cursor_r;
      next_r   <= next_sum;
    end else if (cmd.red_from_mod) begin
      red_r <= mod_rem[CURSOR_W-1:0];
    end
    if (cmd.capture_wa) begin
      wa_r <= rd_q_r;
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.mul1) begin
        prod_r[l] <= (17'(signed'(rd_q_r[16*l +: 16])) - 17'(signed'(wa_r[16*l +: 16])))
                     * $signed({1'b0, red_r[15:0]});
      end
      if (cmd.mul2) begin
        track_r[l] <= ((34'(signed'(wa_r[16*l +: 16])) <<< 16) + prod_r[l])
                      * $signed({1'b0, gain_r});
      end
    end
  end

  // Add the scaled track sample, truncate the Q.32 sum toward zero and saturate.
  always_comb begin
    logic signed [53:0] total;
    logic signed [21:0] q;
    logic               rnd;
    for (int l = 0; l < 2; l++) begin
      total = (54'(smp_r[l]) <<< 32) + 54'(track_r[l]);
      rnd   = total[53] && (total[31:0] != '0);
      q     = $signed(total[53:32]) + $signed({21'b0, rnd});
      if (q > 22'sd32767) begin
        mixed[l] = 16'sh7fff;
      end else if (q < -22'sd32768) begin
        mixed[l] = -16'sh8000;
      end else begin
        mixed[l] = q[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      if (cmd.out_pass) begin
        out_l_r <= smp_r[0];
        out_r_r <= smp_r[1];
      end else begin
        out_l_r <= mixed[0];
        out_r_r <= mixed[1];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mixed_left  = out_l_r;
  assign out_mixed_right = out_r_r;

endmodule

>>> rtl/lrtm_ctrl.sv
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module lrtm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrtm_pkg::dp_status_t status,
  output lrtm_pkg::ctrl_cmd_t  cmd
);
  import lrtm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MODC = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_MODN = 4'd7;
  localparam logic [3:0] S_PASS = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.op_mix) begin
            if (status.bypass) begin
              state_nxt = S_PASS;
            end else if (status.cur_in_range) begin
              state_nxt = S_RDA;
            end else begin
              // The cursor lies beyond a shortened track: reduce it first.
              cmd.mod_start = 1'b1;
              state_nxt     = S_MODC;
            end
          end
        end
      end
      S_MODC: begin
        if (status.mod_done) begin
          cmd.red_from_mod = 1'b1;
          state_nxt        = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        cmd.rd_sel_b   = 1'b1;
        cmd.capture_wa = 1'b1;
        state_nxt      = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.next_in_range) begin
            cmd.cursor_from_next = 1'b1;
            state_nxt            = S_IDLE;
          end else begin
            cmd.mod_start    = 1'b1;
            cmd.mod_sel_next = 1'b1;
            state_nxt        = S_MODN;
          end
        end
      end
      S_MODN: begin
        cmd.mod_sel_next = 1'b1;
        if (status.mod_done) begin
          cmd.cursor_from_mod = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_PASS: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pass = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/looping_resampling_track_mixer.sv
// Looping resampling track mixer top level: controller plus datapath.
//
// A stereo track is loaded frame by frame with write items and then mixed,
// linearly interpolated at the phase cursor, into the incoming stream by mix
// items; a restart item puts the cursor back at the first frame. Write,
// restart and ignored items are done as they are accepted; a mix item that
// passes its input through goes straight to the output register. For a mixed
// item the single-port track store is read once for each of the two
// neighbouring frames, and the interpolation and gain multipliers each have a
// stage of their own. When the cursor wraps past the end of the track, or lies
// beyond a track that has been shortened, a bit-serial remainder unit reduces
// it. The track store has no reset; frames must be written before playback
// reaches them. A mix item waits inside the block, and further items are held
// off, while the output register still holds an item that has not been taken.
`timescale 1ns / 1ps

module looping_resampling_track_mixer #(
  parameter int FRAME_ADDR_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic [15:0]                          in_frame_index,
  input  logic signed [lrtm_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [lrtm_pkg::SAMPLE_W-1:0] in_right_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lrtm_pkg::SAMPLE_W-1:0] out_mixed_left,
  output logic signed [lrtm_pkg::SAMPLE_W-1:0] out_mixed_right,
  input  logic                                 cfg_wr_en,
  input  logic [lrtm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lrtm_pkg::CFG_W-1:0]           cfg_data
);
  import lrtm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lrtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lrtm_datapath #(
    .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (in_opcode),
    .in_frame_index  (in_frame_index),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mixed_left  (out_mixed_left),
    .out_mixed_right (out_mixed_right),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

endmodule
